FILE: design/bfa_pkg.sv
`timescale 1ns / 1ps

package bfa_pkg;

    localparam int MAX_FRAMES  = 4096;
    localparam int WORD_BITS   = 32;
    localparam int MAP_WORDS   = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int WORD_SHIFT  = $clog2(WORD_BITS);
    localparam int FRAME_IDX_W = $clog2(MAX_FRAMES);
    localparam int WORD_IDX_W  = $clog2(MAP_WORDS);
    localparam int SCAN_W      = WORD_IDX_W + 1;
    localparam int PAGE_SHIFT  = 12;

    localparam int CMD_W   = 2;
    localparam int FRAME_W = 20;
    localparam int ADDR_W  = 32;
    localparam int CNT_W   = 13;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    localparam logic [CNT_W-1:0] FRAME_COUNT_RESET = CNT_W'(MAX_FRAMES);

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_RESERVE = 2'd1,
        CMD_FREE    = 2'd2,
        CMD_NONE    = 2'd3
    } cmd_t;

    // register index, taken from paddr above the byte offset
    localparam logic [APB_ADDR_W-3:0] REG_FRAME_COUNT = '0;

    typedef logic [FRAME_W-1:0]   frame_t;
    typedef logic [WORD_BITS-1:0] map_word_t;

endpackage

FILE: design/bfa_in_if.sv
`timescale 1ns / 1ps

interface bfa_in_if;
    import bfa_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CMD_W-1:0]     command;
    logic [FRAME_W-1:0]   existing_frame;
    logic                 kernel_page;
    logic                 rw_page;
    logic [ADDR_W-1:0]    phys_addr;

    modport source (
        output valid, command, existing_frame, kernel_page, rw_page, phys_addr,
        input  ready
    );

    modport sink (
        input  valid, command, existing_frame, kernel_page, rw_page, phys_addr,
        output ready
    );
endinterface

FILE: design/bfa_out_if.sv
`timescale 1ns / 1ps

interface bfa_out_if;
    import bfa_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [FRAME_W-1:0]   frame;
    logic                 present;
    logic                 writable;
    logic                 user;
    logic                 status;

    modport source (
        output valid, frame, present, writable, user, status,
        input  ready
    );

    modport sink (
        input  valid, frame, present, writable, user, status,
        output ready
    );
endinterface

FILE: design/bfa_ram.sv
`timescale 1ns / 1ps

module bfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: design/bitmap_frame_allocator_unit.sv
`timescale 1ns / 1ps

// Bitmap page-frame allocator. One used/free bit per 4 KiB frame, kept in a
// 128 x 32 synchronous RAM; a row that was never written reads as all free.
// Channels: req takes one command transfer (allocate, reserve, free), rsp
// returns exactly one result transfer per command. frame_count is written
// over the APB port at byte address 0, by the user only while the block is
// idle; the block itself does not enforce this. Steps from request transfer
// to result valid, each ending in the output register: allocate with a held
// frame, reserve or free out of range, unused code: straight to the result;
// reserve or free in range: read, modify and write back one row; allocate
// with a scan: one row per cycle, then bit search and write of the hit row.
// One command is in flight at a time; req.ready is high whenever the
// sequencer is idle, even if the previous result still waits in the output
// register. A stalled receiver holds that result and, once the next
// command finishes, holds the sequencer until the register drains.
// Reset clears the row valid bits (every frame free at once), sets
// frame_count to 4096 and empties the output register; no clearing pass.
module bitmap_frame_allocator_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    bfa_in_if.sink                         req,
    bfa_out_if.source                      rsp,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bfa_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [bfa_pkg::APB_DATA_W-1:0] pwdata,
    output logic [bfa_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);
    import bfa_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FIND,
        ST_RD,
        ST_WR,
        ST_RESP
    } state_t;

    state_t                 state_reg;
    logic [CNT_W-1:0]       frame_count_reg;

    // latched command
    cmd_t                   cmd_reg;
    logic                   wr_bit_reg;
    logic                   user_bit_reg;
    frame_t                 tgt_frame_reg;

    // pending result
    frame_t                 res_frame_reg;
    logic                   res_present_reg;
    logic                   res_status_reg;

    // scan pipeline
    logic [SCAN_W-1:0]      scan_idx_reg;
    logic                   chk_pend_reg;
    logic [WORD_IDX_W-1:0]  chk_idx_reg;
    logic [WORD_IDX_W-1:0]  hit_idx_reg;
    map_word_t              hit_word_reg;

    // row valid bits: an unwritten row reads as all free
    logic [MAP_WORDS-1:0]   row_vld_reg;
    logic                   rd_vld_reg;

    // output register
    logic                   out_valid_reg;
    frame_t                 out_frame_reg;
    logic                   out_present_reg;
    logic                   out_writable_reg;
    logic                   out_user_reg;
    logic                   out_status_reg;

    // RAM ports
    logic                   ram_we;
    logic [WORD_IDX_W-1:0]  ram_waddr;
    map_word_t              ram_wdata;
    logic [WORD_IDX_W-1:0]  ram_raddr;
    map_word_t              ram_rdata;
    map_word_t              row_data;

    logic [CNT_W-1:0]       live_count;
    logic [SCAN_W-1:0]      live_words;
    logic [WORD_SHIFT-1:0]  free_bit;
    logic                   req_fire;
    logic                   cfg_write;
    logic                   out_free;
    logic                   scan_hit;
    logic                   scan_more;
    logic [WORD_SHIFT-1:0]  tgt_bit;
    logic [WORD_IDX_W-1:0]  tgt_row;
    frame_t                 rsv_frame;

    bfa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_WORDS)
    ) u_map_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ---------------------------------------------------------------
    // Configuration port
    // ---------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite
                       && (paddr[APB_ADDR_W-1:2] == REG_FRAME_COUNT);

    always_comb
    begin
        prdata = '0;
        if (paddr[APB_ADDR_W-1:2] == REG_FRAME_COUNT)
        begin
            prdata = APB_DATA_W'(frame_count_reg);
        end
    end

    // clamp to the bitmap size; only whole rows below the count are scanned
    assign live_count = (frame_count_reg > CNT_W'(MAX_FRAMES)) ? CNT_W'(MAX_FRAMES)
                                                                : frame_count_reg;
    assign live_words = SCAN_W'(live_count >> WORD_SHIFT);

    // ---------------------------------------------------------------
    // Datapath helpers
    // ---------------------------------------------------------------
    assign req_fire  = req.valid && req.ready;
    assign req.ready = (state_reg == ST_IDLE);
    assign out_free  = !out_valid_reg || rsp.ready;

    assign row_data  = rd_vld_reg ? ram_rdata : '0;
    assign scan_hit  = chk_pend_reg && (row_data != '1);
    assign scan_more = (scan_idx_reg < live_words);

    assign tgt_row   = tgt_frame_reg[FRAME_IDX_W-1:WORD_SHIFT];
    assign tgt_bit   = tgt_frame_reg[WORD_SHIFT-1:0];
    assign rsv_frame = FRAME_W'(req.phys_addr >> PAGE_SHIFT);

    // lowest clear bit of the captured row
    always_comb
    begin
        free_bit = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (!hit_word_reg[i])
            begin
                free_bit = WORD_SHIFT'(i);
            end
        end
    end

    // RAM control: scan reads stream, the rest is read then write back
    always_comb
    begin
        ram_raddr = tgt_row;
        ram_we    = 1'b0;
        ram_waddr = tgt_row;
        ram_wdata = row_data;
        case (state_reg)
            ST_SCAN:
            begin
                ram_raddr = scan_idx_reg[WORD_IDX_W-1:0];
            end
            ST_FIND:
            begin
                ram_we    = 1'b1;
                ram_waddr = hit_idx_reg;
                ram_wdata = hit_word_reg | (map_word_t'(1) << free_bit);
            end
            ST_WR:
            begin
                ram_we = 1'b1;
                if (cmd_reg == CMD_RESERVE)
                begin
                    ram_wdata = row_data | (map_word_t'(1) << tgt_bit);
                end
                else
                begin
                    ram_wdata = row_data & ~(map_word_t'(1) << tgt_bit);
                end
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Valid bits for the map rows
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_vld_reg <= '0;
            rd_vld_reg  <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= row_vld_reg[ram_raddr];
            if (ram_we)
            begin
                row_vld_reg[ram_waddr] <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------
    // Sequencer and output register
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            frame_count_reg <= FRAME_COUNT_RESET;
            out_valid_reg   <= 1'b0;
            chk_pend_reg    <= 1'b0;
            scan_idx_reg    <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                frame_count_reg <= pwdata[CNT_W-1:0];
            end

            if (out_valid_reg && rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (req_fire)
                    begin
                        cmd_reg         <= cmd_t'(req.command);
                        wr_bit_reg      <= req.rw_page;
                        user_bit_reg    <= !req.kernel_page;
                        res_frame_reg   <= '0;
                        res_present_reg <= 1'b0;
                        res_status_reg  <= 1'b0;
                        tgt_frame_reg   <= req.existing_frame;
                        state_reg       <= ST_RESP;
                        case (cmd_t'(req.command))
                            CMD_ALLOC:
                            begin
                                if (req.existing_frame != '0)
                                begin
                                    res_frame_reg   <= req.existing_frame;
                                    res_present_reg <= 1'b1;
                                end
                                else
                                begin
                                    scan_idx_reg <= '0;
                                    chk_pend_reg <= 1'b0;
                                    state_reg    <= ST_SCAN;
                                end
                            end
                            CMD_RESERVE:
                            begin
                                res_frame_reg   <= rsv_frame;
                                res_present_reg <= 1'b1;
                                tgt_frame_reg   <= rsv_frame;
                                if (rsv_frame < FRAME_W'(live_count))
                                begin
                                    state_reg <= ST_RD;
                                end
                            end
                            CMD_FREE:
                            begin
                                if ((req.existing_frame != '0)
                                    && (req.existing_frame < FRAME_W'(MAX_FRAMES)))
                                begin
                                    state_reg <= ST_RD;
                                end
                            end
                            default:
                            begin
                                state_reg <= ST_RESP;
                            end
                        endcase
                    end
                end
                ST_SCAN:
                begin
                    if (scan_hit)
                    begin
                        hit_idx_reg  <= chk_idx_reg;
                        hit_word_reg <= row_data;
                        chk_pend_reg <= 1'b0;
                        state_reg    <= ST_FIND;
                    end
                    else if (scan_more)
                    begin
                        chk_pend_reg <= 1'b1;
                        chk_idx_reg  <= scan_idx_reg[WORD_IDX_W-1:0];
                        scan_idx_reg <= scan_idx_reg + SCAN_W'(1);
                    end
                    else
                    begin
                        // no free frame: report status, leave the map alone
                        chk_pend_reg   <= 1'b0;
                        res_status_reg <= 1'b1;
                        state_reg      <= ST_RESP;
                    end
                end
                ST_FIND:
                begin
                    res_frame_reg   <= FRAME_W'({hit_idx_reg, free_bit});
                    res_present_reg <= 1'b1;
                    state_reg       <= ST_RESP;
                end
                ST_RD:
                begin
                    state_reg <= ST_WR;
                end
                ST_WR:
                begin
                    state_reg <= ST_RESP;
                end
                ST_RESP:
                begin
                    if (out_free)
                    begin
                        out_valid_reg    <= 1'b1;
                        out_frame_reg    <= res_frame_reg;
                        out_present_reg  <= res_present_reg;
                        out_writable_reg <= res_present_reg && wr_bit_reg;
                        out_user_reg     <= res_present_reg && user_bit_reg;
                        out_status_reg   <= res_status_reg;
                        state_reg        <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.frame    = out_frame_reg;
    assign rsp.present  = out_present_reg;
    assign rsp.writable = out_writable_reg;
    assign rsp.user     = out_user_reg;
    assign rsp.status   = out_status_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> (state_reg != ST_IDLE))
        else $error("sequencer stayed idle after a request transfer");

    a_fail_not_present: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !(rsp.status && rsp.present))
        else $error("failed allocation reported as present");

    a_hit_row_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIND) |-> (hit_word_reg != '1))
        else $error("bit search on a full row");

    a_write_only_in_update: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> ((state_reg == ST_FIND) || (state_reg == ST_WR)))
        else $error("map write outside an update step");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (scan_idx_reg <= live_words))
        else $error("scan ran past the managed rows");

    a_result_not_overwritten: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !rsp.ready) |=> out_valid_reg)
        else $error("pending result dropped");

endmodule

FILE: verif/bitmap_frame_allocator_unit_tb.sv
`timescale 1ns / 1ps

import bfa_pkg::*;

typedef struct packed {
    frame_t frame;
    logic   present;
    logic   writable;
    logic   user;
    logic   status;
} frame_result_t;

// Tracks the used/free bitmap alongside the block and holds the results
// still owed on the response channel, oldest first.
class frame_map_scoreboard;
    logic [CNT_W-1:0] frame_count;
    map_word_t        used_map [MAP_WORDS];
    frame_result_t    pending_results [$];
    int               errors;

    function new();
        frame_count = FRAME_COUNT_RESET;
        foreach (used_map[i]) used_map[i] = '0;
        errors = 0;
    endfunction

    function void set_frame_count(logic [CNT_W-1:0] value);
        frame_count = value;
    endfunction

    function int live_frames();
        return (frame_count > MAX_FRAMES) ? MAX_FRAMES : int'(frame_count);
    endfunction

    function int outstanding();
        return pending_results.size();
    endfunction

    // Apply one accepted command to the bitmap and queue its result.
    function frame_result_t note_request(cmd_t cmd, frame_t held, bit kern, bit wr,
                                         logic [ADDR_W-1:0] addr);
        frame_result_t r;
        int            live;
        int            w;
        int            b;
        bit            found;
        frame_t        f;
        r     = '0;
        live  = live_frames();
        found = 0;
        f     = '0;
        case (cmd)
            CMD_ALLOC:
            begin
                if (held != 0)
                begin
                    r.frame    = held;
                    r.present  = 1'b1;
                    r.writable = wr;
                    r.user     = ~kern;
                end
                else
                begin
                    // whole words only: a trailing partial word is never scanned
                    for (w = 0; w < live / WORD_BITS && !found; w++)
                    begin
                        if (used_map[w] != '1)
                        begin
                            for (b = 0; b < WORD_BITS && !found; b++)
                            begin
                                if (!used_map[w][b])
                                begin
                                    found = 1;
                                    f     = frame_t'(w * WORD_BITS + b);
                                end
                            end
                        end
                    end
                    if (found)
                    begin
                        used_map[int'(f) / WORD_BITS][int'(f) % WORD_BITS] = 1'b1;
                        r.frame    = f;
                        r.present  = 1'b1;
                        r.writable = wr;
                        r.user     = ~kern;
                    end
                    else
                    begin
                        r.status = 1'b1;
                    end
                end
            end
            CMD_RESERVE:
            begin
                f          = addr[ADDR_W-1:PAGE_SHIFT];
                r.frame    = f;
                r.present  = 1'b1;
                r.writable = wr;
                r.user     = ~kern;
                if (int'(f) < live)
                    used_map[int'(f) / WORD_BITS][int'(f) % WORD_BITS] = 1'b1;
            end
            CMD_FREE:
            begin
                if (held != 0 && int'(held) < MAX_FRAMES)
                    used_map[int'(held) / WORD_BITS][int'(held) % WORD_BITS] = 1'b0;
            end
            default:
            begin
            end
        endcase
        pending_results.push_back(r);
        return r;
    endfunction

    function void check_result(frame_result_t got);
        frame_result_t want;
        bit            bad;
        bad = 0;
        if (pending_results.size() == 0)
        begin
            $display("%0t: result with none expected: frame %0d present %0b status %0b",
                     $time, got.frame, got.present, got.status);
            errors++;
            return;
        end
        want = pending_results.pop_front();
        if (got.frame !== want.frame)
        begin
            $display("%0t: frame mismatch: expected %0d, actual %0d",
                     $time, want.frame, got.frame);
            bad = 1;
        end
        if (got.present !== want.present)
        begin
            $display("%0t: present mismatch: expected %0b, actual %0b",
                     $time, want.present, got.present);
            bad = 1;
        end
        if (got.writable !== want.writable)
        begin
            $display("%0t: writable mismatch: expected %0b, actual %0b",
                     $time, want.writable, got.writable);
            bad = 1;
        end
        if (got.user !== want.user)
        begin
            $display("%0t: user mismatch: expected %0b, actual %0b",
                     $time, want.user, got.user);
            bad = 1;
        end
        if (got.status !== want.status)
        begin
            $display("%0t: status mismatch: expected %0b, actual %0b",
                     $time, want.status, got.status);
            bad = 1;
        end
        if (bad)
            errors++;
    endfunction
endclass

module bitmap_frame_allocator_unit_tb;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 5;
    localparam int MAX_GAP        = 18;
    // Settle a bit past the longest allocate scan after the final drain.
    localparam int END_SETTLE     = 150;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int LONG_HOLD      = 300;
    localparam int PHASE_ITEMS    = 100;
    localparam int HELD_LIMIT     = 64;

    logic clk;
    logic rst_n;

    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    bfa_in_if  req_if ();
    bfa_out_if rsp_if ();

    bitmap_frame_allocator_unit uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_if.sink),
        .rsp     (rsp_if.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    frame_map_scoreboard frame_sb;

    // Frames handed out so far; frees are mostly drawn from here so that
    // the bitmap keeps churning instead of just filling up.
    frame_t held_frames [$];

    // Pacing knobs: a quiet side never idles, otherwise it waits a random gap from draw_gap.
    bit send_quiet;
    bit recv_quiet;
    int rsp_hold_cycles;
    int idle_cycles;

    initial clk = 1'b0;
    always #CLK_HALF clk = ~clk;

    function automatic int draw_gap(bit quiet);
        return quiet ? 0 : int'($urandom_range(0, MAX_GAP));
    endfunction

    // Watchdog: count cycles with no transfer on either channel.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
                $display("bitmap_frame_allocator_unit test failed");
                $finish;
            end
        end
    end

    // Receiver: draw a wait per result, hold ready low for it, then take the
    // next transfer. A long hold requested by the main thread replaces one draw.
    initial
    begin
        int            gap;
        int            taken;
        frame_result_t got;
        taken        = 0;
        rsp_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (rsp_hold_cycles > 0)
            begin
                gap             = rsp_hold_cycles;
                rsp_hold_cycles = 0;
            end
            else
            begin
                gap = draw_gap(recv_quiet);
            end
            if (gap > 0)
            begin
                rsp_if.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_if.ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp_if.valid);
            got.frame    = rsp_if.frame;
            got.present  = rsp_if.present;
            got.writable = rsp_if.writable;
            got.user     = rsp_if.user;
            got.status   = rsp_if.status;
            frame_sb.check_result(got);
            taken++;
            // switch between a steady sink and a bursty one every so often
            if (taken % 32 == 0)
                recv_quiet = ($urandom_range(0, 3) == 0);
        end
    end

    // Offer one command, hold it until the transfer, and record the
    // prediction at that edge. valid stays high on return; the next caller
    // either reuses it or drops it.
    task automatic send_request(cmd_t cmd, frame_t held, bit kern, bit wr,
                                logic [ADDR_W-1:0] addr);
        int            gap;
        frame_result_t predicted;
        gap = draw_gap(send_quiet);
        if (gap > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid          <= 1'b1;
        req_if.command        <= cmd;
        req_if.existing_frame <= held;
        req_if.kernel_page    <= kern;
        req_if.rw_page        <= wr;
        req_if.phys_addr      <= addr;
        do
            @(posedge clk);
        while (!req_if.ready);
        predicted = frame_sb.note_request(cmd, held, kern, wr, addr);
        if ((cmd == CMD_ALLOC || cmd == CMD_RESERVE) && predicted.present
            && predicted.frame != 0 && int'(predicted.frame) < MAX_FRAMES)
        begin
            held_frames.push_back(predicted.frame);
            if (held_frames.size() > HELD_LIMIT)
                void'(held_frames.pop_front());
        end
    endtask

    // Drop valid and wait until every owed result has been taken.
    task automatic wait_drained();
        req_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (frame_sb.outstanding() != 0);
    endtask

    // APB write: setup cycle, then access cycle until pready.
    task automatic write_frame_count(logic [CNT_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_FRAME_COUNT, 2'b00};
        pwdata  <= APB_DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        frame_sb.set_frame_count(value);
    endtask

    task automatic reconfigure(logic [CNT_W-1:0] value);
        wait_drained();
        write_frame_count(value);
    endtask

    // One random command. Mostly well-formed traffic: allocations, frees of
    // frames actually handed out, reserves near the managed range; the rest
    // is full-width noise.
    task automatic send_random_item();
        int                pick;
        int                idx;
        frame_t            held;
        bit                kern;
        bit                wr;
        logic [ADDR_W-1:0] addr;
        logic [FRAME_W-1:0] f;
        pick = $urandom_range(0, 99);
        kern = $urandom_range(0, 1);
        wr   = $urandom_range(0, 1);
        addr = $urandom;
        held = frame_t'($urandom);
        if (pick < 40)
        begin
            send_request(CMD_ALLOC, '0, kern, wr, addr);
        end
        else if (pick < 50)
        begin
            if (held == 0)
                held = frame_t'($urandom_range(1, 200));
            send_request(CMD_ALLOC, held, kern, wr, addr);
        end
        else if (pick < 70)
        begin
            if (held_frames.size() > 0)
            begin
                idx  = $urandom_range(0, held_frames.size() - 1);
                held = held_frames[idx];
                held_frames.delete(idx);
            end
            else
            begin
                held = frame_t'($urandom_range(0, 300));
            end
            send_request(CMD_FREE, held, kern, wr, addr);
        end
        else if (pick < 80)
        begin
            f    = FRAME_W'($urandom_range(0, frame_sb.live_frames() + 7));
            addr = {f, addr[PAGE_SHIFT-1:0]};
            send_request(CMD_RESERVE, held, kern, wr, addr);
        end
        else if (pick < 90)
        begin
            send_request(CMD_RESERVE, held, kern, wr, addr);
        end
        else if (pick < 96)
        begin
            if ($urandom_range(0, 1) == 0)
                held = frame_t'($urandom_range(0, 300));
            send_request(CMD_FREE, held, kern, wr, addr);
        end
        else
        begin
            send_request(CMD_NONE, held, kern, wr, addr);
        end
    endtask

    // Directed opening: field extremes, every command and the corner cases.
    task automatic run_directed();
        // reset state: everything free, frame 0 is the first one handed out
        send_request(CMD_ALLOC,   '0,          1'b0, 1'b1, '0);
        send_request(CMD_ALLOC,   '0,          1'b1, 1'b0, '1);
        // entry already holds a frame: flags only
        send_request(CMD_ALLOC,   20'hFFFFF,   1'b1, 1'b1, '0);
        send_request(CMD_ALLOC,   20'h00001,   1'b0, 1'b0, '1);
        send_request(CMD_RESERVE, '0,          1'b0, 1'b1, 32'h0000_5ABC);
        send_request(CMD_ALLOC,   '0,          1'b0, 1'b1, '0);
        // reserve above the range: reported but nothing marked
        send_request(CMD_RESERVE, 20'hFFFFF,   1'b1, 1'b1, 32'hFFFF_FFFF);
        send_request(CMD_RESERVE, '0,          1'b0, 1'b0, 32'h00FF_F000);
        // free with no frame (frame 0), a real frame, beyond the bitmap, the last frame
        send_request(CMD_FREE,    '0,          1'b1, 1'b1, '1);
        send_request(CMD_FREE,    20'h00001,   1'b0, 1'b0, '0);
        send_request(CMD_ALLOC,   '0,          1'b1, 1'b1, '0);
        send_request(CMD_FREE,    20'hFFFFF,   1'b1, 1'b0, '0);
        send_request(CMD_FREE,    20'd4095,    1'b0, 1'b1, '0);
        // unused code
        send_request(CMD_NONE,    20'hFFFFF,   1'b1, 1'b1, '1);
        send_request(CMD_NONE,    '0,          1'b0, 1'b0, '0);

        // empty range: no free frame, reserve never marks, free still clears
        reconfigure('0);
        send_request(CMD_ALLOC,   '0,          1'b0, 1'b1, '0);
        send_request(CMD_RESERVE, '0,          1'b0, 1'b1, 32'h0000_0000);
        send_request(CMD_FREE,    20'd5,       1'b1, 1'b0, '0);

        // oversized count behaves as the full bitmap
        reconfigure('1);
        send_request(CMD_ALLOC,   '0,          1'b1, 1'b0, '0);
        send_request(CMD_RESERVE, '0,          1'b0, 1'b0, 32'h00FF_FFFF);

        // only a partial word: allocate finds nothing, reserve still marks
        reconfigure(CNT_W'(31));
        send_request(CMD_ALLOC,   '0,          1'b0, 1'b1, '0);
        send_request(CMD_RESERVE, '0,          1'b1, 1'b1, 32'h0001_E123);
        send_request(CMD_RESERVE, '0,          1'b1, 1'b1, 32'h0001_F000);
        send_request(CMD_ALLOC,   '0,          1'b1, 1'b1, '0);
    endtask

    initial
    begin
        int phase_counts [10];
        int p;
        int i;
        phase_counts = '{64, 4096, 32, 100, 8191, 1, 160, 4096, 33, 96};
        frame_sb        = new();
        rsp_hold_cycles = 0;
        idle_cycles     = 0;
        send_quiet      = 1'b0;
        recv_quiet      = 1'b0;

        rst_n                 = 1'b0;
        req_if.valid          <= 1'b0;
        req_if.command        <= CMD_ALLOC;
        req_if.existing_frame <= '0;
        req_if.kernel_page    <= 1'b0;
        req_if.rw_page        <= 1'b0;
        req_if.phys_addr      <= '0;
        psel                  <= 1'b0;
        penable               <= 1'b0;
        pwrite                <= 1'b0;
        paddr                 <= '0;
        pwdata                <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        for (p = 0; p < 10; p++)
        begin
            reconfigure(CNT_W'(phase_counts[p]));
            for (i = 0; i < PHASE_ITEMS; i++)
            begin
                if (i % 25 == 0)
                    send_quiet = ($urandom_range(0, 3) == 0);
                // stall the sink for a long stretch while commands keep coming,
                // so the output register fills and the input backs up
                if (p == 1 && i == 10)
                    rsp_hold_cycles = LONG_HOLD;
                // pause the source until the block has fully drained
                if (p == 3 && i == 50)
                    wait_drained();
                send_random_item();
            end
        end

        wait_drained();
        repeat (END_SETTLE) @(posedge clk);
        if (frame_sb.errors == 0 && frame_sb.outstanding() == 0)
        begin
            $display("bitmap_frame_allocator_unit test passed");
        end
        else
        begin
            $display("bitmap_frame_allocator_unit test failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
design/bfa_pkg.sv
design/bfa_in_if.sv
design/bfa_out_if.sv
design/bfa_ram.sv
design/bitmap_frame_allocator_unit.sv
verif/bitmap_frame_allocator_unit_tb.sv
